/* rtl/znm_pkg.sv */
// Shared types and constants of the zone neighbor mask block.
// Used by the channel interfaces, the register file, controller and datapath.
`default_nettype none

package znm_pkg;

	localparam int IDX_W   = 6;
	localparam int MASK_W  = 64;
	localparam int GRID_W  = 7;
	localparam int FIX_W   = 32;
	localparam int RIDX_W  = 3;
	localparam int ST_W    = 2;
	localparam int PLANE_W = 2 * GRID_W;
	localparam int TOTAL_W = 3 * GRID_W;

	localparam logic [RIDX_W-1:0] REG_GRID_X = 3'd0;
	localparam logic [RIDX_W-1:0] REG_GRID_Y = 3'd1;
	localparam logic [RIDX_W-1:0] REG_GRID_Z = 3'd2;
	localparam logic [RIDX_W-1:0] REG_SIZE_X = 3'd3;
	localparam logic [RIDX_W-1:0] REG_SIZE_Y = 3'd4;
	localparam logic [RIDX_W-1:0] REG_SIZE_Z = 3'd5;
	localparam logic [RIDX_W-1:0] REG_RADIUS = 3'd6;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_TOO_MANY  = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd2;

	localparam logic [GRID_W-1:0] GRID_RESET = 7'd1;
	localparam logic [FIX_W-1:0]  FIX_ONE    = 32'h0001_0000;

	typedef struct packed {
		logic [GRID_W-1:0] gx;
		logic [GRID_W-1:0] gy;
		logic [GRID_W-1:0] gz;
		logic [FIX_W-1:0]  sx;
		logic [FIX_W-1:0]  sy;
		logic [FIX_W-1:0]  sz;
		logic [FIX_W-1:0]  rad;
	} cfg_t;

	typedef struct packed {
		logic            start;
		logic            mul_plane;
		logic            mul_total;
		logic            sq_step;
		logic            walk_step;
		logic            walk_clear;
		logic            latch_coord;
		logic            issue;
		logic            load_out;
		logic [ST_W-1:0] status;
	} ctrl_cmd_t;

	typedef struct packed {
		logic too_many;
		logic bad_index;
		logic sq_last;
		logic at_q;
		logic scan_last;
		logic pipe_empty;
		logic out_busy;
	} dp_sts_t;

endpackage

`default_nettype wire

/* rtl/znm_ifs.sv */
// Valid/ready channel interfaces: query word, result word, register write word.
// Depends on znm_pkg for field widths.
`default_nettype none

interface znm_req_if;
	logic                      valid;
	logic                      ready;
	logic [znm_pkg::IDX_W-1:0] zone_index;
	modport source (output valid, output zone_index, input ready);
	modport sink   (input valid, input zone_index, output ready);
endinterface

interface znm_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [znm_pkg::MASK_W-1:0] neighbor_mask;
	logic [znm_pkg::ST_W-1:0]   status;
	modport source (output valid, output neighbor_mask, output status, input ready);
	modport sink   (input valid, input neighbor_mask, input status, output ready);
endinterface

interface znm_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [znm_pkg::RIDX_W-1:0] index;
	logic [znm_pkg::FIX_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/zone_neighbor_mask_core.sv */
// Zone neighbor mask: one query word in, one 64-bit mask word plus status out.
// A valid query runs a size check, squares of sizes and radius, a walk that locates the
// queried index q, a one-candidate-a-cycle scan of all N zones, a drain and the hand-off;
// an error goes from the check to the hand-off. A query is taken only after the last is
// handed off; the result register frees the input while a word waits on rsp.ready.
// Reset: arst_n clears control, sets grid 1x1x1, sizes and radius to 1.0.
`default_nettype none

module zone_neighbor_mask_core #(
	parameter int MAX_ZONES = 64
) (
	input  wire       clk,
	input  wire       arst_n,
	znm_req_if.sink   req,
	znm_rsp_if.source rsp,
	znm_cfg_if.sink   cfg
);
	import znm_pkg::*;

	cfg_t       regs;
	ctrl_cmd_t  cmd;
	dp_sts_t    sts;
	logic       ctrl_ready;

	assign req.ready = ctrl_ready;

	znm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	znm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ctrl_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	znm_dp #(
		.MAX_ZONES (MAX_ZONES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.regs       (regs),
		.zone_index (req.zone_index),
		.cmd        (cmd),
		.sts        (sts),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

/* rtl/znm_cfg_regs.sv */
// Configuration register file: grid dimensions, zone sizes and radius.
// Depends on znm_pkg and znm_cfg_if.
`default_nettype none

module znm_cfg_regs (
	input  wire           clk,
	input  wire           arst_n,
	znm_cfg_if.sink       cfg,
	output znm_pkg::cfg_t regs
);
	import znm_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.gx  <= GRID_RESET;
			regs_q.gy  <= GRID_RESET;
			regs_q.gz  <= GRID_RESET;
			regs_q.sx  <= FIX_ONE;
			regs_q.sy  <= FIX_ONE;
			regs_q.sz  <= FIX_ONE;
			regs_q.rad <= FIX_ONE;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_GRID_X: regs_q.gx  <= cfg.data[GRID_W-1:0];
				REG_GRID_Y: regs_q.gy  <= cfg.data[GRID_W-1:0];
				REG_GRID_Z: regs_q.gz  <= cfg.data[GRID_W-1:0];
				REG_SIZE_X: regs_q.sx  <= cfg.data;
				REG_SIZE_Y: regs_q.sy  <= cfg.data;
				REG_SIZE_Z: regs_q.sz  <= cfg.data;
				REG_RADIUS: regs_q.rad <= cfg.data;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/znm_ctrl.sv */
// Query sequencer: size check, squares setup, locate, scan, drain, result hand-off.
// Depends on znm_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none

module znm_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_ready,
	input  znm_pkg::dp_sts_t   sts,
	output znm_pkg::ctrl_cmd_t cmd
);
	import znm_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DIMS1  = 9'b000000010,
		S_DIMS2  = 9'b000000100,
		S_CHECK  = 9'b000001000,
		S_SQR    = 9'b000010000,
		S_LOCATE = 9'b000100000,
		S_SCAN   = 9'b001000000,
		S_DRAIN  = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t          state_q, state_n;
	logic [ST_W-1:0] st_q, st_n;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_n    = state_q;
		st_n       = st_q;
		cmd        = '0;
		cmd.status = st_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.start = 1'b1;
					state_n   = S_DIMS1;
				end
			end
			S_DIMS1: begin
				cmd.mul_plane = 1'b1;
				state_n       = S_DIMS2;
			end
			S_DIMS2: begin
				cmd.mul_total = 1'b1;
				state_n       = S_CHECK;
			end
			S_CHECK: begin
				if (sts.too_many) begin
					st_n    = ST_TOO_MANY;
					state_n = S_DONE;
				end else if (sts.bad_index) begin
					st_n    = ST_BAD_INDEX;
					state_n = S_DONE;
				end else begin
					st_n    = ST_OK;
					state_n = S_SQR;
				end
			end
			S_SQR: begin
				cmd.sq_step = 1'b1;
				if (sts.sq_last)
					state_n = S_LOCATE;
			end
			S_LOCATE: begin
				if (sts.at_q) begin
					cmd.latch_coord = 1'b1;
					cmd.walk_clear  = 1'b1;
					state_n         = S_SCAN;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.scan_last)
					state_n = S_DRAIN;
			end
			S_DRAIN: begin
				if (sts.pipe_empty)
					state_n = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_n;
			st_q    <= st_n;
		end
	end

endmodule

`default_nettype wire

/* rtl/znm_dp.sv */
// Datapath: zone counts, squared sizes, grid walk, distance pipeline, mask and result word.
// Depends on znm_pkg and znm_rsp_if; steered by znm_ctrl.
`default_nettype none

module znm_dp #(
	parameter int MAX_ZONES = 64
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  znm_pkg::cfg_t             regs,
	input  wire [znm_pkg::IDX_W-1:0]  zone_index,
	input  znm_pkg::ctrl_cmd_t        cmd,
	output znm_pkg::dp_sts_t          sts,
	znm_rsp_if.source                 rsp
);
	import znm_pkg::*;

	localparam int SQ_W   = 2 * FIX_W;
	localparam int D2_W   = 2 * IDX_W;
	localparam int PROD_W = SQ_W + D2_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam logic [TOTAL_W-1:0] MaxZonesW = TOTAL_W'(MAX_ZONES);

	logic [IDX_W-1:0]   q_q;
	logic [PLANE_W-1:0] plane_q;
	logic [TOTAL_W-1:0] total_q;

	logic [1:0]       sq_idx_q;
	logic [FIX_W-1:0] sq_op;
	logic [SQ_W-1:0]  sq_prod;
	logic [SQ_W-1:0]  sqx_q, sqy_q, sqz_q, r2_q;

	logic [IDX_W-1:0] b_cnt_q, bx_q, by_q, bz_q;
	logic [IDX_W-1:0] qx_q, qy_q, qz_q;
	logic             x_wrap, y_wrap;

	logic [IDX_W-1:0]  dx, dy, dz;
	logic [D2_W-1:0]   dx2_s1, dy2_s1, dz2_s1;
	logic [IDX_W-1:0]  b_s1, b_s2, b_s3;
	logic              v_s1, v_s2, v_s3;
	logic [PROD_W-1:0] px_s2, py_s2, pz_s2;
	logic [SUM_W-1:0]  sum_s3;
	logic              in_radius;

	logic [MASK_W-1:0] mask_q;
	logic [MASK_W-1:0] out_mask_q;
	logic [ST_W-1:0]   out_status_q;
	logic              out_valid_q;

	// Zone counts and query index
	always_ff @(posedge clk) begin
		if (cmd.start)
			q_q <= zone_index;
		if (cmd.mul_plane)
			plane_q <= PLANE_W'(regs.gx) * PLANE_W'(regs.gy);
		if (cmd.mul_total)
			total_q <= TOTAL_W'(plane_q) * TOTAL_W'(regs.gz);
	end

	// Squared sizes and radius, one product a cycle
	always_comb begin
		case (sq_idx_q)
			2'd0:    sq_op = regs.sx;
			2'd1:    sq_op = regs.sy;
			2'd2:    sq_op = regs.sz;
			default: sq_op = regs.rad;
		endcase
	end

	assign sq_prod = SQ_W'(sq_op) * SQ_W'(sq_op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_idx_q <= '0;
		else if (cmd.start)
			sq_idx_q <= '0;
		else if (cmd.sq_step)
			sq_idx_q <= sq_idx_q + 2'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_step) begin
			case (sq_idx_q)
				2'd0:    sqx_q <= sq_prod;
				2'd1:    sqy_q <= sq_prod;
				2'd2:    sqz_q <= sq_prod;
				default: r2_q  <= sq_prod;
			endcase
		end
	end

	// Grid walk, x fastest
	assign x_wrap = ({1'b0, bx_q} + GRID_W'(1)) == regs.gx;
	assign y_wrap = ({1'b0, by_q} + GRID_W'(1)) == regs.gy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_cnt_q <= '0;
			bx_q    <= '0;
			by_q    <= '0;
			bz_q    <= '0;
		end else if (cmd.start || cmd.walk_clear) begin
			b_cnt_q <= '0;
			bx_q    <= '0;
			by_q    <= '0;
			bz_q    <= '0;
		end else if (cmd.walk_step || cmd.issue) begin
			b_cnt_q <= b_cnt_q + IDX_W'(1);
			if (x_wrap) begin
				bx_q <= '0;
				if (y_wrap) begin
					by_q <= '0;
					bz_q <= bz_q + IDX_W'(1);
				end else begin
					by_q <= by_q + IDX_W'(1);
				end
			end else begin
				bx_q <= bx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_coord) begin
			qx_q <= bx_q;
			qy_q <= by_q;
			qz_q <= bz_q;
		end
	end

	// Distance pipeline: axis distance squared, scaled, summed, compared
	assign dx = (bx_q > qx_q) ? (bx_q - qx_q) : (qx_q - bx_q);
	assign dy = (by_q > qy_q) ? (by_q - qy_q) : (qy_q - by_q);
	assign dz = (bz_q > qz_q) ? (bz_q - qz_q) : (qz_q - bz_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue && (b_cnt_q != q_q);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx2_s1 <= D2_W'(dx) * D2_W'(dx);
		dy2_s1 <= D2_W'(dy) * D2_W'(dy);
		dz2_s1 <= D2_W'(dz) * D2_W'(dz);
		b_s1   <= b_cnt_q;
		px_s2  <= PROD_W'(dx2_s1) * PROD_W'(sqx_q);
		py_s2  <= PROD_W'(dy2_s1) * PROD_W'(sqy_q);
		pz_s2  <= PROD_W'(dz2_s1) * PROD_W'(sqz_q);
		b_s2   <= b_s1;
		sum_s3 <= SUM_W'(px_s2) + SUM_W'(py_s2) + SUM_W'(pz_s2);
		b_s3   <= b_s2;
	end

	assign in_radius = sum_s3 <= SUM_W'(r2_q);

	always_ff @(posedge clk) begin
		if (cmd.start)
			mask_q <= '0;
		else if (v_s3 && in_radius)
			mask_q[b_s3] <= 1'b1;
	end

	// Result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_mask_q   <= mask_q;
			out_status_q <= cmd.status;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.neighbor_mask = out_mask_q;
	assign rsp.status        = out_status_q;

	assign sts.too_many   = total_q > MaxZonesW;
	assign sts.bad_index  = TOTAL_W'(q_q) >= total_q;
	assign sts.sq_last    = (sq_idx_q == 2'd3);
	assign sts.at_q       = (b_cnt_q == q_q);
	assign sts.scan_last  = (TOTAL_W'(b_cnt_q) + TOTAL_W'(1)) == total_q;
	assign sts.pipe_empty = !(v_s1 || v_s2 || v_s3);
	assign sts.out_busy   = out_valid_q && !rsp.ready;

	a_walk_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> ({1'b0, bx_q} < regs.gx) && ({1'b0, by_q} < regs.gy)
			&& ({1'b0, bz_q} < regs.gz))
		else $error("scan walked outside the grid");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && !rsp.ready))
		else $error("result word overwritten while held");

	a_error_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && (cmd.status != ST_OK) |=> (out_mask_q == '0))
		else $error("error result with nonzero mask");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

`default_nettype wire
